FILE: sv/cfuv_pkg.sv
// Shared constants and types for the cube face UV projection block.
`default_nettype none
package cfuv_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int UV_WIDTH    = 16;
  localparam int NUM_W       = COORD_WIDTH + 1;
  localparam int FACE_W      = 3;

  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

  // Per-transaction data moving down the divider chain.
  typedef struct packed {
    logic [NUM_W-1:0]    rem_u;
    logic [NUM_W-1:0]    rem_v;
    logic [NUM_W-1:0]    divisor;
    logic [UV_WIDTH-1:0] quot_u;
    logic [UV_WIDTH-1:0] quot_v;
    logic [FACE_W-1:0]   face;
    logic                zero;
  } stage_t;

endpackage
`default_nettype wire

FILE: sv/cfuv_front.sv
// Face selection, projection and divider setup stage.
`default_nettype none
module cfuv_front (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     in_valid,
  input  wire logic signed [cfuv_pkg::COORD_WIDTH-1:0]  coord_x,
  input  wire logic signed [cfuv_pkg::COORD_WIDTH-1:0]  coord_y,
  input  wire logic signed [cfuv_pkg::COORD_WIDTH-1:0]  coord_z,
  output logic                                          out_valid,
  output cfuv_pkg::stage_t                              out_stage
);

  localparam int CW = cfuv_pkg::COORD_WIDTH;
  localparam int NW = cfuv_pkg::NUM_W;

  logic signed [NW-1:0] xe, ye, ze, xn, yn, zn;
  logic [CW-1:0]        ax, ay, az, m;
  logic signed [NW-1:0] s, t;
  logic signed [NW:0]   sum_u, sum_v;
  logic [cfuv_pkg::FACE_W-1:0] face;
  logic                 zero;
  cfuv_pkg::stage_t     stage_next;

  always_comb begin
    xe = NW'(coord_x);
    ye = NW'(coord_y);
    ze = NW'(coord_z);
    xn = -xe;
    yn = -ye;
    zn = -ze;
    ax = xe[NW-1] ? CW'(xn) : CW'(xe);
    ay = ye[NW-1] ? CW'(yn) : CW'(ye);
    az = ze[NW-1] ? CW'(zn) : CW'(ze);
    zero = (coord_x == '0) && (coord_y == '0) && (coord_z == '0);
    if (az >= ax && az >= ay) begin
      m = az;
      if (coord_z > 0) begin
        face = cfuv_pkg::FACE_POS_Z; s = xe; t = ye;
      end else begin
        face = cfuv_pkg::FACE_NEG_Z; s = xn; t = ye;
      end
    end else if (ay >= ax && ay >= az) begin
      m = ay;
      if (coord_y > 0) begin
        face = cfuv_pkg::FACE_POS_Y; s = xe; t = zn;
      end else begin
        face = cfuv_pkg::FACE_NEG_Y; s = xe; t = ze;
      end
    end else begin
      m = ax;
      if (coord_x > 0) begin
        face = cfuv_pkg::FACE_POS_X; s = zn; t = ye;
      end else begin
        face = cfuv_pkg::FACE_NEG_X; s = ze; t = ye;
      end
    end
    sum_u = (NW+1)'(s) + $signed({2'b00, m});
    sum_v = (NW+1)'(t) + $signed({2'b00, m});
    stage_next.rem_u   = sum_u[NW-1:0];
    stage_next.rem_v   = sum_v[NW-1:0];
    stage_next.divisor = {m, 1'b0};
    stage_next.quot_u  = '0;
    stage_next.quot_v  = '0;
    stage_next.face    = face;
    stage_next.zero    = zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_stage <= stage_next;
  end

endmodule
`default_nettype wire

FILE: sv/cfuv_cell.sv
// One divider cell: produces one quotient bit for both u and v lanes.
`default_nettype none
module cfuv_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire cfuv_pkg::stage_t in_stage,
  output logic                  out_valid,
  output cfuv_pkg::stage_t      out_stage
);

  localparam int NW = cfuv_pkg::NUM_W;
  localparam int UW = cfuv_pkg::UV_WIDTH;

  logic [NW:0]      tu, tv, dx;
  logic             bit_u, bit_v;
  cfuv_pkg::stage_t stage_next;

  always_comb begin
    tu = {in_stage.rem_u, 1'b0};
    tv = {in_stage.rem_v, 1'b0};
    dx = {1'b0, in_stage.divisor};
    bit_u = (tu >= dx);
    bit_v = (tv >= dx);
    stage_next = in_stage;
    stage_next.rem_u  = bit_u ? NW'(tu - dx) : NW'(tu);
    stage_next.rem_v  = bit_v ? NW'(tv - dx) : NW'(tv);
    stage_next.quot_u = {in_stage.quot_u[UW-2:0], bit_u};
    stage_next.quot_v = {in_stage.quot_v[UW-2:0], bit_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_stage <= stage_next;
  end

endmodule
`default_nettype wire

FILE: sv/cube_face_uv_projection.sv
// Cube map face selection and face UV top level: front stage, divider cell chain, output register.
// A direction is taken in every cycle (busy is always low). Its result
// appears on the result ports after passing the face-select stage, the
// chain of divider cells (one quotient bit per cell) and the output
// register, and is marked by done for one cycle. The receiver cannot
// stall: each result must be taken in the cycle that done is high.
`default_nettype none
module cube_face_uv_projection (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     start,
  output logic                                          busy,
  input  wire logic signed [cfuv_pkg::COORD_WIDTH-1:0]  coord_x,
  input  wire logic signed [cfuv_pkg::COORD_WIDTH-1:0]  coord_y,
  input  wire logic signed [cfuv_pkg::COORD_WIDTH-1:0]  coord_z,
  output logic                                          done,
  output logic [cfuv_pkg::UV_WIDTH-1:0]                 tex_u,
  output logic [cfuv_pkg::UV_WIDTH-1:0]                 tex_v,
  output logic [cfuv_pkg::FACE_W-1:0]                   face_index,
  output logic                                          zero_vector
);

  localparam int UW  = cfuv_pkg::UV_WIDTH;
  localparam int LAT = UW + 2;

  logic             accept;
  logic             pipe_valid [0:UW];
  cfuv_pkg::stage_t pipe_stage [0:UW];
  cfuv_pkg::stage_t last;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cfuv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .out_valid (pipe_valid[0]),
    .out_stage (pipe_stage[0])
  );

  for (genvar i = 0; i < UW; i++) begin : g_cell
    cfuv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (pipe_valid[i]),
      .in_stage  (pipe_stage[i]),
      .out_valid (pipe_valid[i+1]),
      .out_stage (pipe_stage[i+1])
    );
  end

  assign last = pipe_stage[UW];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pipe_valid[UW];
    end
    tex_u       <= last.zero ? '0 : last.quot_u;
    tex_v       <= last.zero ? '0 : last.quot_v;
    face_index  <= last.face;
    zero_vector <= last.zero;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("transaction result missing at expected latency");

  a_zero_uv: assert property (@(posedge clk) disable iff (rst)
    (done && zero_vector) |-> (tex_u == '0 && tex_v == '0))
    else $error("zero vector with nonzero uv");

  a_zero_face: assert property (@(posedge clk) disable iff (rst)
    (done && zero_vector) |-> (face_index == cfuv_pkg::FACE_NEG_Z))
    else $error("zero vector not mapped to -z face");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst, LAT)) |-> $past(accept, LAT))
    else $error("result without a transaction");

endmodule
`default_nettype wire
